// ===== design/icmr_pkg.sv =====
`default_nettype none
package icmr_pkg;

    localparam int DATA_W        = 32;
    localparam int LINE_W        = 8;
    localparam int IDX_W         = 5;
    localparam int CMD_W         = 2;
    localparam int ROUTE_WORDS   = 4;
    localparam int ROUTE_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int SRC_PER_WORD  = DATA_W / ROUTE_W;

    localparam int NUM_SOURCES_DEF   = 32;
    localparam int NUM_CPU_LINES_DEF = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    localparam logic REG_MASK   = 1'b0;
    localparam logic REG_STATUS = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] status;
        logic [DATA_W-1:0] n_mask;
        logic [DATA_W-1:0] n_status;
        logic [DATA_W-1:0] rdata;
    } t_state_view;

endpackage
`default_nettype wire

// ===== design/icmr_req_if.sv =====
`default_nettype none
interface icmr_req_if;
    import icmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic                reg_index;
    logic [DATA_W-1:0]   write_data;
    logic [DATA_W-1:0]   source_levels;

    modport source (output valid, cmd, reg_index, write_data, source_levels, input ready);
    modport sink   (input valid, cmd, reg_index, write_data, source_levels, output ready);
endinterface
`default_nettype wire

// ===== design/icmr_rsp_if.sv =====
`default_nettype none
interface icmr_rsp_if;
    import icmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_data;
    logic [LINE_W-1:0]   cpu_lines;
    logic                pending_any;
    logic [IDX_W-1:0]    lowest_pending;

    modport source (output valid, read_data, cpu_lines, pending_any, lowest_pending,
                    input ready);
    modport sink   (input valid, read_data, cpu_lines, pending_any, lowest_pending,
                    output ready);
endinterface
`default_nettype wire

// ===== design/interrupt_controller_mask_route_unit.sv =====
// An accepted word's result word is registered and shows on o_rsp in the cycle after it is taken.
// Throughput: one word per cycle; a new word is taken while the result register
// is empty or being drained in the same cycle.
// Reset (synchronous, active low): mask, status and route registers clear to
// zero and the result register empties.
`default_nettype none
module interrupt_controller_mask_route_unit #(
    parameter int NUM_SOURCES   = icmr_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CPU_LINES = icmr_pkg::NUM_CPU_LINES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    icmr_req_if.sink                            i_req,
    icmr_rsp_if.source                          o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [icmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [icmr_pkg::DATA_W-1:0]    i_cfg_data
);
    import icmr_pkg::*;

    t_state_view        view;
    logic               accept;
    logic [DATA_W-1:0]  pending;
    logic [LINE_W-1:0]  lines;
    logic               any;
    logic [IDX_W-1:0]   lowest;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_read_data;
    logic [LINE_W-1:0]  r_cpu_lines;
    logic               r_pending_any;
    logic [IDX_W-1:0]   r_lowest;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    icmr_state #(.NUM_SOURCES(NUM_SOURCES)) u_state (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_cmd           (i_req.cmd),
        .i_reg_index     (i_req.reg_index),
        .i_write_data    (i_req.write_data),
        .i_source_levels (i_req.source_levels),
        .o_view          (view)
    );

    assign pending = view.n_mask & view.n_status;

    icmr_route #(.NUM_SOURCES(NUM_SOURCES), .NUM_CPU_LINES(NUM_CPU_LINES)) u_route (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pending   (pending),
        .o_lines     (lines)
    );

    icmr_prio #(.NUM_SOURCES(NUM_SOURCES)) u_prio (
        .i_pending (pending),
        .o_any     (any),
        .o_lowest  (lowest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data   <= view.rdata;
            r_cpu_lines   <= lines;
            r_pending_any <= any;
            r_lowest      <= lowest;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.read_data      = r_read_data;
    assign o_rsp.cpu_lines      = r_cpu_lines;
    assign o_rsp.pending_any    = r_pending_any;
    assign o_rsp.lowest_pending = r_lowest;

    a_mask_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.cmd == CMD_READ && i_req.reg_index == REG_MASK
        |=> o_rsp.valid && o_rsp.read_data == $past(view.mask))
        else $error("mask read returned wrong data");

    a_tick_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.cmd == CMD_TICK
        |=> ((view.status & $past(i_req.source_levels) & DATA_W'({NUM_SOURCES{1'b1}}))
             == ($past(i_req.source_levels) & DATA_W'({NUM_SOURCES{1'b1}}))))
        else $error("tick lost a source level");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.pending_any
        |-> o_rsp.cpu_lines == '0 && o_rsp.lowest_pending == '0)
        else $error("lines or index set with nothing pending");

    a_line0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_rsp.cpu_lines[0])
        else $error("cpu line 0 driven");

endmodule
`default_nettype wire

// ===== design/icmr_state.sv =====
`default_nettype none
module icmr_state #(
    parameter int NUM_SOURCES = icmr_pkg::NUM_SOURCES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [icmr_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic                        i_reg_index,
    input  wire logic [icmr_pkg::DATA_W-1:0] i_write_data,
    input  wire logic [icmr_pkg::DATA_W-1:0] i_source_levels,
    output icmr_pkg::t_state_view            o_view
);
    import icmr_pkg::*;

    logic [NUM_SOURCES-1:0] r_mask, n_mask;
    logic [NUM_SOURCES-1:0] r_status, n_status;
    logic [DATA_W-1:0]      rdata;

    always_comb begin
        n_mask   = r_mask;
        n_status = r_status;
        rdata    = '0;
        case (t_cmd'(i_cmd))
            CMD_TICK: begin
                n_status = r_status | i_source_levels[NUM_SOURCES-1:0];
            end
            CMD_READ: begin
                rdata = (i_reg_index == REG_STATUS) ? DATA_W'(r_status) : DATA_W'(r_mask);
            end
            CMD_WRITE: begin
                if (i_reg_index == REG_STATUS) begin
                    n_status = r_status & ~i_write_data[NUM_SOURCES-1:0];
                end else begin
                    n_mask = i_write_data[NUM_SOURCES-1:0];
                end
            end
            default: begin
                rdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_status <= '0;
        end else if (i_accept) begin
            r_mask   <= n_mask;
            r_status <= n_status;
        end
    end

    assign o_view.mask     = DATA_W'(r_mask);
    assign o_view.status   = DATA_W'(r_status);
    assign o_view.n_mask   = DATA_W'(n_mask);
    assign o_view.n_status = DATA_W'(n_status);
    assign o_view.rdata    = rdata;

endmodule
`default_nettype wire

// ===== design/icmr_route.sv =====
`default_nettype none
module icmr_route #(
    parameter int NUM_SOURCES   = icmr_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CPU_LINES = icmr_pkg::NUM_CPU_LINES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [icmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [icmr_pkg::DATA_W-1:0]    i_cfg_data,
    input  wire logic [icmr_pkg::DATA_W-1:0]    i_pending,
    output      logic [icmr_pkg::LINE_W-1:0]    o_lines
);
    import icmr_pkg::*;

    logic [DATA_W-1:0] r_route [ROUTE_WORDS];
    logic [ROUTE_W-1:0] nib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < ROUTE_WORDS; w++) begin
                r_route[w] <= '0;
            end
        end else if (i_cfg_we) begin
            r_route[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        o_lines = '0;
        nib     = '0;
        for (int s = 0; s < NUM_SOURCES; s++) begin
            nib = r_route[s / SRC_PER_WORD][(s % SRC_PER_WORD) * ROUTE_W +: ROUTE_W];
            for (int k = 1; k < NUM_CPU_LINES; k++) begin
                if (i_pending[s] && nib == ROUTE_W'(k)) begin
                    o_lines[k] = 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/icmr_prio.sv =====
`default_nettype none
module icmr_prio #(
    parameter int NUM_SOURCES = icmr_pkg::NUM_SOURCES_DEF
) (
    input  wire logic [icmr_pkg::DATA_W-1:0] i_pending,
    output      logic                        o_any,
    output      logic [icmr_pkg::IDX_W-1:0]  o_lowest
);
    import icmr_pkg::*;

    always_comb begin
        o_any    = |i_pending[NUM_SOURCES-1:0];
        o_lowest = '0;
        for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
            if (i_pending[s]) begin
                o_lowest = IDX_W'(s);
            end
        end
    end

endmodule
`default_nettype wire
